[rtl/arw_pkg.sv]
// Shared constants for the anti-replay window checker.
package arw_pkg;

  localparam int unsigned SeqW               = 32;
  localparam int unsigned TimeW              = 32;
  localparam int unsigned WindowBytesDefault = 8;

endpackage

[rtl/arw_decide.sv]
// Accept/reject decision and next window state for one packet.
module arw_decide #(
  parameter int unsigned WindowBytes = arw_pkg::WindowBytesDefault,
  parameter int unsigned WinBits     = WindowBytes * 8,
  parameter int unsigned PosW        = $clog2(WinBits)
) (
  input  logic [arw_pkg::SeqW-1:0]  seq_num_i,
  input  logic [arw_pkg::TimeW-1:0] recv_time_i,
  input  logic [arw_pkg::SeqW-1:0]  highest_seq_i,
  input  logic [arw_pkg::TimeW-1:0] reset_time_i,
  input  logic [arw_pkg::TimeW-1:0] latest_time_i,
  input  logic [PosW-1:0]           ring_pos_i,
  input  logic [WinBits-1:0]        seen_i,
  output logic [arw_pkg::SeqW-1:0]  highest_seq_o,
  output logic [arw_pkg::TimeW-1:0] reset_time_o,
  output logic [arw_pkg::TimeW-1:0] latest_time_o,
  output logic [PosW-1:0]           ring_pos_o,
  output logic [WinBits-1:0]        seen_o,
  output logic                      accepted_o
);
  import arw_pkg::*;

  localparam logic [SeqW-1:0] WinSeq = SeqW'(WinBits);
  localparam logic [PosW:0]   WinPos = (PosW+1)'(WinBits);

  logic            time_before;
  logic            advance;
  logic            newer;
  logic            wipe_jump;
  logic            too_old;
  logic [SeqW-1:0] gap;
  logic [SeqW-1:0] back;
  logic [PosW:0]   gap_n;
  logic [PosW:0]   pos_sum;
  logic [PosW:0]   pos_adv;
  logic [PosW:0]   slot_n;
  logic [PosW-1:0] slot;
  logic [WinBits-1:0] clr_mask;
  logic [WinBits-1:0] set_mask;

  assign time_before = recv_time_i < reset_time_i;
  assign advance     = seq_num_i > highest_seq_i;
  assign newer       = recv_time_i > latest_time_i;
  assign gap         = seq_num_i - highest_seq_i;
  assign back        = highest_seq_i - seq_num_i;
  assign wipe_jump   = gap > WinSeq;
  assign too_old     = back >= WinSeq;

  // Only meaningful when the gap is at most one window, so it fits here.
  assign gap_n   = gap[PosW:0];
  assign pos_sum = {1'b0, ring_pos_i} + gap_n;
  assign pos_adv = (pos_sum >= WinPos) ? pos_sum - WinPos : pos_sum;

  // Slot of an in-window number; back is below one window here.
  assign slot_n = ({1'b0, ring_pos_i} >= {1'b0, back[PosW-1:0]}) ?
                  {1'b0, ring_pos_i} - {1'b0, back[PosW-1:0]} :
                  {1'b0, ring_pos_i} + WinPos - {1'b0, back[PosW-1:0]};
  assign slot   = slot_n[PosW-1:0];

  // Every slot strictly between the old and new ring positions is cleared.
  for (genvar i = 0; i < WinBits; i++) begin : g_mask
    logic [PosW:0] idx;
    logic [PosW:0] off;
    assign idx         = (PosW+1)'(i);
    assign off         = (idx >= {1'b0, ring_pos_i}) ? idx - {1'b0, ring_pos_i} :
                         idx + WinPos - {1'b0, ring_pos_i};
    assign clr_mask[i] = (off != '0) && (off < gap_n);
    assign set_mask[i] = (idx == pos_adv);
  end

  always_comb begin
    highest_seq_o = highest_seq_i;
    reset_time_o  = reset_time_i;
    latest_time_o = latest_time_i;
    ring_pos_o    = ring_pos_i;
    seen_o        = seen_i;
    accepted_o    = 1'b0;
    priority if (time_before) begin
      accepted_o = 1'b0;
    end else if (advance) begin
      highest_seq_o = seq_num_i;
      latest_time_o = recv_time_i;
      accepted_o    = 1'b1;
      if (wipe_jump) begin
        ring_pos_o = '0;
        seen_o     = WinBits'(1);
      end else begin
        ring_pos_o = pos_adv[PosW-1:0];
        seen_o     = (seen_i & ~clr_mask) | set_mask;
      end
    end else if (newer) begin
      highest_seq_o = seq_num_i;
      reset_time_o  = recv_time_i;
      latest_time_o = recv_time_i;
      ring_pos_o    = '0;
      seen_o        = WinBits'(1);
      accepted_o    = 1'b1;
    end else if (too_old) begin
      accepted_o = 1'b0;
    end else if (!seen_i[slot]) begin
      seen_o[slot] = 1'b1;
      accepted_o   = 1'b1;
    end else begin
      accepted_o = 1'b0;
    end
  end

endmodule

[rtl/anti_replay_window_check.sv]
// A packet is held in the input register, then its result in the result register.
// Throughput: one packet per cycle unless the output stalls; window state is updated in
// the cycle that decides a packet, so the next packet in the input register sees it.
// Reset clears the highest number, both time stamps, the ring position and the
// seen bitmap; the block takes packets in the first cycle after reset.
module anti_replay_window_check #(
  parameter int unsigned WindowBytes = arw_pkg::WindowBytesDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [arw_pkg::SeqW-1:0]  seq_num_i,
  input  logic [arw_pkg::TimeW-1:0] recv_time_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      accepted_o
);
  import arw_pkg::*;

  localparam int unsigned WinBits = WindowBytes * 8;
  localparam int unsigned PosW    = $clog2(WinBits);

  logic             in_valid_q;
  logic [SeqW-1:0]  seq_q;
  logic [TimeW-1:0] time_q;
  logic             out_valid_q;
  logic             accepted_q;
  logic             decide;

  logic [SeqW-1:0]    highest_q,  highest_d;
  logic [TimeW-1:0]   reset_t_q,  reset_t_d;
  logic [TimeW-1:0]   latest_t_q, latest_t_d;
  logic [PosW-1:0]    pos_q,      pos_d;
  logic [WinBits-1:0] seen_q,     seen_d;
  logic               accepted_d;

  // A packet is decided when it sits in the input register and the result
  // register is free or being emptied in this cycle.
  assign decide      = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || decide;
  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;

  arw_decide #(
    .WindowBytes (WindowBytes),
    .WinBits     (WinBits),
    .PosW        (PosW)
  ) u_decide (
    .seq_num_i     (seq_q),
    .recv_time_i   (time_q),
    .highest_seq_i (highest_q),
    .reset_time_i  (reset_t_q),
    .latest_time_i (latest_t_q),
    .ring_pos_i    (pos_q),
    .seen_i        (seen_q),
    .highest_seq_o (highest_d),
    .reset_time_o  (reset_t_d),
    .latest_time_o (latest_t_d),
    .ring_pos_o    (pos_d),
    .seen_o        (seen_d),
    .accepted_o    (accepted_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      highest_q   <= '0;
      reset_t_q   <= '0;
      latest_t_q  <= '0;
      pos_q       <= '0;
      seen_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (decide) begin
        out_valid_q <= 1'b1;
        highest_q   <= highest_d;
        reset_t_q   <= reset_t_d;
        latest_t_q  <= latest_t_d;
        pos_q       <= pos_d;
        seen_q      <= seen_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      seq_q  <= seq_num_i;
      time_q <= recv_time_i;
    end
    if (decide) begin
      accepted_q <= accepted_d;
    end
  end

endmodule
